>>> rtl/core/sspq_pkg.sv
// Shared constants and types for the stable sorted priority queue.
package sspq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRIO_W   = 16;
    localparam int TAG_W    = 16;
    localparam int STAT_W   = 2;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [STAT_W-1:0] ST_PUSH_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMIT    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic              insert;
        logic              shift;
        logic              load;
        logic [STAT_W-1:0] status;
        logic              last;
        logic              take_entry;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } sts_t;

endpackage

>>> rtl/core/sspq_ctrl.sv
// Controller state machine: request decode, drain sequencing, output valid.
module sspq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_req_type,
    output logic           m_valid,
    input  logic           m_ready,
    input  sspq_pkg::sts_t sts,
    output sspq_pkg::cmd_t cmd
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.status     = sspq_pkg::ST_PUSH_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type == sspq_pkg::REQ_PUSH) begin
                        cmd.insert = !sts.full;
                        cmd.load   = 1'b1;
                        cmd.status = sts.full ? sspq_pkg::ST_DROPPED : sspq_pkg::ST_PUSH_OK;
                        cmd.last   = 1'b1;
                    end else if (sts.empty) begin
                        cmd.load   = 1'b1;
                        cmd.status = sspq_pkg::ST_EMPTY;
                        cmd.last   = 1'b1;
                    end else begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    cmd.load       = 1'b1;
                    cmd.shift      = 1'b1;
                    cmd.take_entry = 1'b1;
                    cmd.status     = sspq_pkg::ST_EMIT;
                    cmd.last       = sts.one_left;
                    if (sts.one_left) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/core/sspq_datapath.sv
// Datapath: sorted row of compare-and-shift cells, fill count, output word register.
module sspq_datapath #(
    parameter int CAPACITY = sspq_pkg::CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [sspq_pkg::PRIO_W-1:0]  s_prio,
    input  logic        [sspq_pkg::TAG_W-1:0]   s_tag,
    input  sspq_pkg::cmd_t                      cmd,
    output sspq_pkg::sts_t                      sts,
    output logic        [sspq_pkg::STAT_W-1:0]  m_status,
    output logic signed [sspq_pkg::PRIO_W-1:0]  m_out_prio,
    output logic        [sspq_pkg::TAG_W-1:0]   m_out_tag,
    output logic                                m_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [sspq_pkg::PRIO_W-1:0] prio_reg [CAPACITY];
    logic signed [sspq_pkg::PRIO_W-1:0] prio_next [CAPACITY];
    logic        [sspq_pkg::TAG_W-1:0]  tag_reg  [CAPACITY];
    logic        [sspq_pkg::TAG_W-1:0]  tag_next [CAPACITY];
    logic        [CAPACITY-1:0]         le;
    logic        [CNT_W-1:0]            count_reg, count_next;

    logic        [sspq_pkg::STAT_W-1:0] status_reg;
    logic signed [sspq_pkg::PRIO_W-1:0] oprio_reg;
    logic        [sspq_pkg::TAG_W-1:0]  otag_reg;
    logic                               last_reg;

    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CNT_W'(CAPACITY));
    assign sts.one_left = (count_reg == CNT_W'(1));

    // stored entry stays in place when it is valid and not above the new priority
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            le[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= s_prio);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            prio_next[i] = prio_reg[i];
            tag_next[i]  = tag_reg[i];
        end
        if (cmd.insert) begin
            if (!le[0]) begin
                prio_next[0] = s_prio;
                tag_next[0]  = s_tag;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!le[i]) begin
                    if (le[i-1]) begin
                        prio_next[i] = s_prio;
                        tag_next[i]  = s_tag;
                    end else begin
                        prio_next[i] = prio_reg[i-1];
                        tag_next[i]  = tag_reg[i-1];
                    end
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                prio_next[i] = prio_reg[i+1];
                tag_next[i]  = tag_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.shift) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            prio_reg[i] <= prio_next[i];
            tag_reg[i]  <= tag_next[i];
        end
        if (cmd.load) begin
            status_reg <= cmd.status;
            oprio_reg  <= cmd.take_entry ? prio_reg[0] : '0;
            otag_reg   <= cmd.take_entry ? tag_reg[0] : '0;
            last_reg   <= cmd.last;
        end
    end

    assign m_status   = status_reg;
    assign m_out_prio = oprio_reg;
    assign m_out_tag  = otag_reg;
    assign m_last     = last_reg;

endmodule

>>> rtl/core/stable_sorted_priority_queue_unit.sv
// Top level of the stable sorted priority queue: controller plus datapath.
// Push: the status word is registered and shows the cycle after acceptance.
// Push throughput: one word per cycle while the result side keeps taking words.
// Drain of n entries: one word per cycle out of the head cell while the result side takes words; input held off.
// Drain of an empty store: one word.
// Synchronous active-low reset empties the store (fill count zero) and clears output valid.
module stable_sorted_priority_queue_unit #(
    parameter int CAPACITY = sspq_pkg::CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic signed [sspq_pkg::PRIO_W-1:0]  s_prio,
    input  logic        [sspq_pkg::TAG_W-1:0]   s_tag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [sspq_pkg::STAT_W-1:0]  m_status,
    output logic signed [sspq_pkg::PRIO_W-1:0]  m_out_prio,
    output logic        [sspq_pkg::TAG_W-1:0]   m_out_tag,
    output logic                                m_last
);

    sspq_pkg::cmd_t cmd;
    sspq_pkg::sts_t sts;

    sspq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    sspq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_prio     (s_prio),
        .s_tag      (s_tag),
        .cmd        (cmd),
        .sts        (sts),
        .m_status   (m_status),
        .m_out_prio (m_out_prio),
        .m_out_tag  (m_out_tag),
        .m_last     (m_last)
    );

endmodule

>>> rtl/core/sspq_checker.sv
// Port-level checker for the stable sorted priority queue, bound to the top level.
module sspq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic        [sspq_pkg::STAT_W-1:0] m_status,
    input logic signed [sspq_pkg::PRIO_W-1:0] m_out_prio,
    input logic        [sspq_pkg::TAG_W-1:0]  m_out_tag,
    input logic                               m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_prio)
            && $stable(m_out_tag) && $stable(m_last))
        else $error("result word changed while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != sspq_pkg::ST_EMIT |-> m_last)
        else $error("status word without last");

    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != sspq_pkg::ST_EMIT |-> m_out_prio == '0 && m_out_tag == '0)
        else $error("status word carries entry data");

    a_drain_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == sspq_pkg::ST_EMIT && !m_last |-> !s_ready)
        else $error("input taken in the middle of a drain");

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_out_prio (m_out_prio),
    .m_out_tag  (m_out_tag),
    .m_last     (m_last)
);

>>> dv/stable_sorted_priority_queue_unit_tb.sv
// Self-checking testbench for the stable sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_unit_tb;

    localparam int RAND_WORDS   = 150;
    localparam int QUIET_WORDS  = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYC   = 40;
    localparam int HOLD_CYC     = 120;
    localparam int HOLD_AFTER   = 60;
    localparam int DIRECTED_N   = 20;

    typedef struct packed {
        logic [sspq_pkg::STAT_W-1:0]        status;
        logic signed [sspq_pkg::PRIO_W-1:0] prio;
        logic [sspq_pkg::TAG_W-1:0]         tag;
        logic                               last;
    } result_word_t;

    typedef struct packed {
        logic                               req;
        logic signed [sspq_pkg::PRIO_W-1:0] prio;
        logic [sspq_pkg::TAG_W-1:0]         tag;
        logic                               has_fixed;
        logic [sspq_pkg::STAT_W-1:0]        fixed_status;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic                               s_req_type;
    logic signed [sspq_pkg::PRIO_W-1:0] s_prio;
    logic [sspq_pkg::TAG_W-1:0]         s_tag;
    logic                               m_valid;
    logic                               m_ready;
    logic [sspq_pkg::STAT_W-1:0]        m_status;
    logic signed [sspq_pkg::PRIO_W-1:0] m_out_prio;
    logic [sspq_pkg::TAG_W-1:0]         m_out_tag;
    logic                               m_last;

    // side band that travels with the input word
    logic                               cur_has_fixed;
    logic [sspq_pkg::STAT_W-1:0]        cur_fixed_status;

    logic signed [sspq_pkg::PRIO_W-1:0] sorted_prio [sspq_pkg::CAPACITY];
    logic [sspq_pkg::TAG_W-1:0]         sorted_tag [sspq_pkg::CAPACITY];
    int                                 sorted_fill;
    result_word_t                       step_words[$];
    result_word_t                       pending_words[$];

    int  fail_count;
    int  words_in;
    bit  quiet;
    bit  hold_done;

    stim_row_t directed_rows [DIRECTED_N] = '{
        '{sspq_pkg::REQ_DRAIN, 16'sh0000, 16'h0000, 1'b1, sspq_pkg::ST_EMPTY},
        '{sspq_pkg::REQ_PUSH,  16'sh8000, 16'h0000, 1'b1, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh7FFF, 16'hFFFF, 1'b1, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh0000, 16'h0001, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh0000, 16'h0002, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'shFFFF, 16'h0003, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh7FFF, 16'h0004, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh8000, 16'h0005, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh0001, 16'h0006, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh0000, 16'h0007, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'shFFFE, 16'h0008, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh0064, 16'h0009, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'shFF9C, 16'h000A, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh7FFE, 16'h000B, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh8001, 16'h000C, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh0000, 16'h5A5A, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh7FFF, 16'hA5A5, 1'b0, sspq_pkg::ST_PUSH_OK},
        '{sspq_pkg::REQ_PUSH,  16'sh1234, 16'hBEEF, 1'b1, sspq_pkg::ST_DROPPED},
        '{sspq_pkg::REQ_DRAIN, 16'sh0000, 16'h0000, 1'b0, sspq_pkg::ST_EMIT},
        '{sspq_pkg::REQ_DRAIN, 16'shFFFF, 16'hFFFF, 1'b1, sspq_pkg::ST_EMPTY}
    };

    stable_sorted_priority_queue_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_prio     (s_prio),
        .s_tag      (s_tag),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_out_prio (m_out_prio),
        .m_out_tag  (m_out_tag),
        .m_last     (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic result_word_t make_word(logic [sspq_pkg::STAT_W-1:0] st,
                                               logic signed [sspq_pkg::PRIO_W-1:0] p,
                                               logic [sspq_pkg::TAG_W-1:0] t, logic lst);
        result_word_t w;
        w.status = st;
        w.prio   = p;
        w.tag    = t;
        w.last   = lst;
        return w;
    endfunction

    // stable insertion: new entry goes after every entry of lower or equal priority
    task automatic sorted_store_step(input logic req,
                                     input logic signed [sspq_pkg::PRIO_W-1:0] p,
                                     input logic [sspq_pkg::TAG_W-1:0] t);
        int pos;
        step_words.delete();
        if (req == sspq_pkg::REQ_PUSH) begin
            if (sorted_fill >= sspq_pkg::CAPACITY) begin
                step_words = {step_words, make_word(sspq_pkg::ST_DROPPED, '0, '0, 1'b1)};
            end else begin
                pos = 0;
                while (pos < sorted_fill && sorted_prio[pos] <= p)
                    pos++;
                for (int i = sorted_fill; i > pos; i--) begin
                    sorted_prio[i] = sorted_prio[i-1];
                    sorted_tag[i]  = sorted_tag[i-1];
                end
                sorted_prio[pos] = p;
                sorted_tag[pos]  = t;
                sorted_fill++;
                step_words = {step_words, make_word(sspq_pkg::ST_PUSH_OK, '0, '0, 1'b1)};
            end
        end else if (sorted_fill == 0) begin
            step_words = {step_words, make_word(sspq_pkg::ST_EMPTY, '0, '0, 1'b1)};
        end else begin
            for (int i = 0; i < sorted_fill; i++)
                step_words = {step_words, make_word(sspq_pkg::ST_EMIT, sorted_prio[i],
                                                    sorted_tag[i], (i == sorted_fill - 1))};
            sorted_fill = 0;
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_word_t exp_w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sorted_store_step(s_req_type, s_prio, s_tag);
                if (cur_has_fixed)
                    pending_words = {pending_words,
                                     make_word(cur_fixed_status, '0, '0, 1'b1)};
                else
                    pending_words = {pending_words, step_words};
                words_in++;
            end
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected result word: status %0d prio %0d tag %0h last %0d",
                           m_status, m_out_prio, m_out_tag, m_last);
                    fail_count++;
                end else begin
                    exp_w = pending_words.pop_front();
                    if (m_status !== exp_w.status) begin
                        $error("status: expected %0d, got %0d", exp_w.status, m_status);
                        fail_count++;
                    end
                    if (m_out_prio !== exp_w.prio) begin
                        $error("out_prio: expected %0d, got %0d", exp_w.prio, m_out_prio);
                        fail_count++;
                    end
                    if (m_out_tag !== exp_w.tag) begin
                        $error("out_tag: expected %0h, got %0h", exp_w.tag, m_out_tag);
                        fail_count++;
                    end
                    if (m_last !== exp_w.last) begin
                        $error("last: expected %0d, got %0d", exp_w.last, m_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall bursts, one long hold-off to back up the input
    initial begin : receiver
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && words_in >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [sspq_pkg::PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 5)) inside
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            [2:3]:   return sspq_pkg::PRIO_W'(int'($urandom_range(0, 6)) - 3);
            default: return sspq_pkg::PRIO_W'($urandom);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic req, input logic signed [sspq_pkg::PRIO_W-1:0] p,
                             input logic [sspq_pkg::TAG_W-1:0] t, input logic fixed,
                             input logic [sspq_pkg::STAT_W-1:0] fixed_st);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= req;
        s_prio           <= p;
        s_tag            <= t;
        cur_has_fixed    <= fixed;
        cur_fixed_status <= fixed_st;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int rand_count;
        int n;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_req_type       = sspq_pkg::REQ_PUSH;
        s_prio           = '0;
        s_tag            = '0;
        cur_has_fixed    = 1'b0;
        cur_fixed_status = sspq_pkg::ST_PUSH_OK;
        fail_count       = 0;
        words_in         = 0;
        sorted_fill      = 0;
        quiet            = 1'b0;
        hold_done        = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].req, directed_rows[i].prio, directed_rows[i].tag,
                      directed_rows[i].has_fixed, directed_rows[i].fixed_status);

        // mostly fill-then-drain runs with random content, some loose words
        rand_count = 0;
        while (rand_count < RAND_WORDS) begin
            quiet = (rand_count >= RAND_WORDS - QUIET_WORDS);
            if ($urandom_range(0, 5) == 0) begin
                send_word(1'($urandom_range(0, 1)), pick_prio(),
                          sspq_pkg::TAG_W'($urandom), 1'b0, sspq_pkg::ST_PUSH_OK);
                rand_count++;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                                : $urandom_range(0, 8);
                repeat (n) begin
                    send_word(sspq_pkg::REQ_PUSH, pick_prio(), sspq_pkg::TAG_W'($urandom),
                              1'b0, sspq_pkg::ST_PUSH_OK);
                    rand_count++;
                end
                send_word(sspq_pkg::REQ_DRAIN, pick_prio(), sspq_pkg::TAG_W'($urandom),
                          1'b0, sspq_pkg::ST_PUSH_OK);
                rand_count++;
            end
        end
        s_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (fail_count == 0 && pending_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
